[rtl/dpb_pkg.sv]
// Shared types and constants for the depth pixel back-projection block.
// Holds the configuration record, the controller command record and step codes.
// No dependencies.
package dpb_pkg;

   // Sequencer step codes; the step advances by one each cycle of work on an item.
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_INIT = 4'd0;
   localparam logic [STEP_W-1:0] STEP_ZHI  = 4'd1;
   localparam logic [STEP_W-1:0] STEP_P0   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_P1   = 4'd3;
   localparam logic [STEP_W-1:0] STEP_P2   = 4'd4;
   localparam logic [STEP_W-1:0] STEP_P3   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_LAST = 4'd8;

   // Pixel position counters.
   localparam int PIX_W = 11;

   // Configuration register map.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_RECIPROCAL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VISUAL_MAX_DEPTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_METRE_SCALE      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_COL       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_ROW       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_FOCAL_X      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_FOCAL_Y      = 3'd7;

   localparam logic [11:0] RST_LINE_WIDTH       = 12'd640;
   localparam logic [23:0] RST_UNIT_RECIPROCAL  = 24'd2097;
   localparam logic [15:0] RST_VISUAL_MAX_DEPTH = 16'd1200;
   localparam logic [23:0] RST_METRE_SCALE      = 24'd16777;
   localparam logic [15:0] RST_CENTER_COL       = 16'd5120;
   localparam logic [15:0] RST_CENTER_ROW       = 16'd3840;
   localparam logic [23:0] RST_INV_FOCAL_X      = 24'd36166;
   localparam logic [23:0] RST_INV_FOCAL_Y      = 24'd36166;

   typedef struct packed {
      logic [11:0] line_width;
      logic [23:0] unit_reciprocal;
      logic [15:0] visual_max_depth;
      logic [23:0] metre_scale;
      logic [15:0] center_col;
      logic [15:0] center_row;
      logic [23:0] inv_focal_x;
      logic [23:0] inv_focal_y;
   } cfg_type;

   typedef struct packed {
      logic              accept;
      logic              run;
      logic [STEP_W-1:0] step;
      logic              load_out;
   } cmd_type;

endpackage

[rtl/depth_pixel_backprojection.sv]
// Top level of the depth pixel back-projection block: configuration registers,
// controller and datapath. Depends on dpb_pkg, dpb_ctrl and dpb_datapath.
//
// Usage: raw 16-bit depth pixels arrive in raster order on the req_ channel,
// one per transfer, with req_frame_start marking the first pixel of a frame.
// Each pixel gives exactly one transfer on the rsp_ channel: an 8-bit gray
// level, a point valid flag, x, y, z in Q16.16 meters and the pixel position.
// A new pixel is taken only while the block is idle or in the cycle that the
// last result is loaded. The pace is set by the gray-level divider, which
// retires one quotient bit per cycle after a setup step; the Z multiply and
// the two projection lanes finish while the divider runs.
// The result sits in an output register: while the receiver stalls, the next
// pixel is taken and worked on, and the block then waits with its result
// until the output register frees, taking a new pixel in that same cycle.
// The csr_ port writes one register per cycle with csr_write_en; writes are
// for the user to make only while the block is idle (unenforced). Synchronous
// reset loads register defaults, clears col/row counters, drops rsp_valid.
module depth_pixel_backprojection #(
   parameter int MAX_LINE_WIDTH = 2048
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [dpb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dpb_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [15:0]                    req_depth_raw,
   input  logic                           req_frame_start,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_gray_level,
   output logic                           rsp_point_valid,
   output logic signed [31:0]             rsp_point_x,
   output logic signed [31:0]             rsp_point_y,
   output logic [30:0]                    rsp_point_z,
   output logic [dpb_pkg::PIX_W-1:0]      rsp_pixel_col,
   output logic [dpb_pkg::PIX_W-1:0]      rsp_pixel_row
);

   dpb_pkg::cfg_type cfg_ff, cfg_in;
   dpb_pkg::cmd_type cmd;

   // Register write decode; each register keeps only its own width.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            dpb_pkg::CSR_LINE_WIDTH:       cfg_in.line_width       = csr_wdata[11:0];
            dpb_pkg::CSR_UNIT_RECIPROCAL:  cfg_in.unit_reciprocal  = csr_wdata;
            dpb_pkg::CSR_VISUAL_MAX_DEPTH: cfg_in.visual_max_depth = csr_wdata[15:0];
            dpb_pkg::CSR_METRE_SCALE:      cfg_in.metre_scale      = csr_wdata;
            dpb_pkg::CSR_CENTER_COL:       cfg_in.center_col       = csr_wdata[15:0];
            dpb_pkg::CSR_CENTER_ROW:       cfg_in.center_row       = csr_wdata[15:0];
            dpb_pkg::CSR_INV_FOCAL_X:      cfg_in.inv_focal_x      = csr_wdata;
            dpb_pkg::CSR_INV_FOCAL_Y:      cfg_in.inv_focal_y      = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_width       <= dpb_pkg::RST_LINE_WIDTH;
         cfg_ff.unit_reciprocal  <= dpb_pkg::RST_UNIT_RECIPROCAL;
         cfg_ff.visual_max_depth <= dpb_pkg::RST_VISUAL_MAX_DEPTH;
         cfg_ff.metre_scale      <= dpb_pkg::RST_METRE_SCALE;
         cfg_ff.center_col       <= dpb_pkg::RST_CENTER_COL;
         cfg_ff.center_row       <= dpb_pkg::RST_CENTER_ROW;
         cfg_ff.inv_focal_x      <= dpb_pkg::RST_INV_FOCAL_X;
         cfg_ff.inv_focal_y      <= dpb_pkg::RST_INV_FOCAL_Y;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The controller owns both handshakes and tells the datapath which step
   // of the pixel's work to perform each cycle.
   dpb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   dpb_datapath #(
      .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .cfg             (cfg_ff),
      .req_depth_raw   (req_depth_raw),
      .req_frame_start (req_frame_start),
      .rsp_gray_level  (rsp_gray_level),
      .rsp_point_valid (rsp_point_valid),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_point_z     (rsp_point_z),
      .rsp_pixel_col   (rsp_pixel_col),
      .rsp_pixel_row   (rsp_pixel_row)
   );

endmodule

[rtl/dpb_lane.sv]
// One projection lane: offset magnitude times reciprocal focal length times Z,
// built from four partial products, then saturated to Q16.16.
// Depends on dpb_pkg.
module dpb_lane (
   input  logic                    clock,
   input  dpb_pkg::cmd_type        cmd,
   input  logic [dpb_pkg::PIX_W-1:0] pos,
   input  logic [15:0]             center,
   input  logic [23:0]             inv_focal,
   input  logic [39:0]             z,
   output logic [31:0]             coord
);

   logic [16:0] diff;
   logic        neg_in;
   logic [15:0] mag_in;
   logic        neg_ff;
   logic [15:0] mag_ff;
   logic [39:0] ax_ff, ax_in;
   logic [79:0] acc_ff, acc_in;
   logic [23:0] mul_a, mul_b;
   logic [47:0] prod;
   logic [51:0] r;
   logic        pos_over, neg_over;
   logic [31:0] pos_val, neg_mag;

   // Signed Q.4 offset of the pixel from the optical center.
   always_comb begin
      diff   = {2'b00, pos, 4'b0000} - {1'b0, center};
      neg_in = diff[16];
      mag_in = neg_in ? 16'(~diff + 17'd1) : diff[15:0];
   end

   always_comb begin
      mul_a = inv_focal;
      mul_b = {8'b0, mag_ff};
      unique case (cmd.step)
         dpb_pkg::STEP_P0: begin
            mul_a = {4'b0, ax_ff[19:0]};
            mul_b = {4'b0, z[19:0]};
         end
         dpb_pkg::STEP_P1: begin
            mul_a = {4'b0, ax_ff[19:0]};
            mul_b = {4'b0, z[39:20]};
         end
         dpb_pkg::STEP_P2: begin
            mul_a = {4'b0, ax_ff[39:20]};
            mul_b = {4'b0, z[19:0]};
         end
         dpb_pkg::STEP_P3: begin
            mul_a = {4'b0, ax_ff[39:20]};
            mul_b = {4'b0, z[39:20]};
         end
         default: begin
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   always_comb begin
      ax_in  = ax_ff;
      acc_in = acc_ff;
      if (cmd.run) begin
         unique case (cmd.step) inside
            dpb_pkg::STEP_INIT: ax_in = prod[39:0];
            dpb_pkg::STEP_P0:   acc_in = {40'b0, prod[39:0]};
            dpb_pkg::STEP_P1, dpb_pkg::STEP_P2:
               acc_in = acc_ff + {20'b0, prod[39:0], 20'b0};
            dpb_pkg::STEP_P3:   acc_in = acc_ff + {prod[39:0], 40'b0};
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         neg_ff <= neg_in;
         mag_ff <= mag_in;
      end
      ax_ff  <= ax_in;
      acc_ff <= acc_in;
   end

   // Magnitude truncated toward zero, then clamped to the signed 32-bit range.
   always_comb begin
      r        = acc_ff[79:28];
      pos_over = |r[51:31];
      neg_over = (|r[51:32]) || (r[31] && (|r[30:0]));
      pos_val  = pos_over ? 32'h7FFF_FFFF : r[31:0];
      neg_mag  = neg_over ? 32'h8000_0000 : r[31:0];
      coord    = neg_ff ? (32'd0 - neg_mag) : pos_val;
   end

endmodule

[rtl/dpb_datapath.sv]
// Datapath: depth scaling, Z multiply, gray-level divider, two projection
// lanes, pixel position counters and the result register.
// Depends on dpb_pkg and dpb_lane.
module dpb_datapath #(
   parameter int MAX_LINE_WIDTH = 2048
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dpb_pkg::cmd_type          cmd,
   input  dpb_pkg::cfg_type          cfg,
   input  logic [15:0]               req_depth_raw,
   input  logic                      req_frame_start,
   output logic [7:0]                rsp_gray_level,
   output logic                      rsp_point_valid,
   output logic signed [31:0]        rsp_point_x,
   output logic signed [31:0]        rsp_point_y,
   output logic [30:0]               rsp_point_z,
   output logic [dpb_pkg::PIX_W-1:0] rsp_pixel_col,
   output logic [dpb_pkg::PIX_W-1:0] rsp_pixel_row
);

   localparam int PW = dpb_pkg::PIX_W;
   localparam int COL_SPAN = 2 ** PW;
   localparam logic [PW:0] COL_LIMIT =
      (PW+1)'((MAX_LINE_WIDTH < COL_SPAN) ? MAX_LINE_WIDTH : COL_SPAN);

   // Position counters.
   logic [PW-1:0] col_cnt_ff, col_cnt_in, row_cnt_ff, row_cnt_in;
   logic [PW-1:0] cur_col, cur_row;
   logic [PW:0]   next_col;
   logic          wrap;
   logic [PW-1:0] pix_col_ff, pix_row_ff;

   // Depth and Z.
   logic [39:0] d_in, d_ff;
   logic [19:0] m0_a;
   logic [43:0] m0_prod, zsum;
   logic [23:0] zlo_ff, zlo_in;
   logic [39:0] z_ff, z_in;

   // Gray-level divider.
   logic [31:0] m_val, diff32;
   logic        en_init, en_ff, en_in, ge;
   logic [39:0] rem_init, rem_ff, rem_in;
   logic [38:0] div_ff, div_in;
   logic [7:0]  q_ff, q_in;

   logic [31:0] lane_x, lane_y;
   logic        pv;

   always_comb begin
      cur_col  = req_frame_start ? '0 : col_cnt_ff;
      cur_row  = req_frame_start ? '0 : row_cnt_ff;
      next_col = {1'b0, cur_col} + (PW+1)'(1);
      wrap     = (next_col >= cfg.line_width) || (next_col >= COL_LIMIT);
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (cmd.accept) begin
         col_cnt_in = wrap ? '0 : next_col[PW-1:0];
         row_cnt_in = wrap ? cur_row + PW'(1) : cur_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
      end
   end

   assign d_in = req_depth_raw * cfg.unit_reciprocal;

   // Z = floor(D * metre_scale / 2^24), in two 20-bit halves of D.
   assign m0_a    = (cmd.step == dpb_pkg::STEP_INIT) ? d_ff[19:0] : d_ff[39:20];
   assign m0_prod = m0_a * cfg.metre_scale;
   assign zsum    = m0_prod + {20'b0, zlo_ff};

   always_comb begin
      m_val    = {cfg.visual_max_depth, 16'b0};
      en_init  = (d_ff != '0) && (cfg.visual_max_depth != '0) && (d_ff < {8'b0, m_val});
      diff32   = m_val - d_ff[31:0];
      rem_init = {diff32, 8'b0} - {8'b0, diff32};
      ge       = en_ff && (rem_ff >= {1'b0, div_ff});

      zlo_in = zlo_ff;
      z_in   = z_ff;
      en_in  = en_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      q_in   = q_ff;
      if (cmd.run) begin
         if (cmd.step == dpb_pkg::STEP_INIT) begin
            zlo_in = m0_prod[43:20];
            en_in  = en_init;
            rem_in = en_init ? rem_init : '0;
            div_in = {m_val, 7'b0};
            q_in   = '0;
         end else begin
            // One quotient bit per step, most significant first.
            rem_in = ge ? rem_ff - {1'b0, div_ff} : rem_ff;
            div_in = div_ff >> 1;
            q_in   = {q_ff[6:0], ge};
         end
         if (cmd.step == dpb_pkg::STEP_ZHI) begin
            z_in = zsum[43:4];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         d_ff       <= d_in;
         pix_col_ff <= cur_col;
         pix_row_ff <= cur_row;
      end
      zlo_ff <= zlo_in;
      z_ff   <= z_in;
      en_ff  <= en_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      q_ff   <= q_in;
   end

   dpb_lane u_lane_x (
      .clock     (clock),
      .cmd       (cmd),
      .pos       (cur_col),
      .center    (cfg.center_col),
      .inv_focal (cfg.inv_focal_x),
      .z         (z_ff),
      .coord     (lane_x)
   );

   dpb_lane u_lane_y (
      .clock     (clock),
      .cmd       (cmd),
      .pos       (cur_row),
      .center    (cfg.center_row),
      .inv_focal (cfg.inv_focal_y),
      .z         (z_ff),
      .coord     (lane_y)
   );

   assign pv = (d_ff != '0);

   // Result register; the quotient is taken from its next value so the last
   // divider step and the load can share a cycle.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_gray_level  <= q_in;
         rsp_point_valid <= pv;
         rsp_point_x     <= pv ? lane_x : '0;
         rsp_point_y     <= pv ? lane_y : '0;
         rsp_point_z     <= !pv ? '0 : ((|z_ff[39:31]) ? 31'h7FFF_FFFF : z_ff[30:0]);
         rsp_pixel_col   <= pix_col_ff;
         rsp_pixel_row   <= pix_row_ff;
      end
   end

endmodule

[rtl/dpb_ctrl.sv]
// Controller: sequences the datapath steps for one pixel and runs the
// handshakes of both channels. Depends on dpb_pkg.
module dpb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dpb_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]                  state_ff, state_in;
   logic [dpb_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        out_free, finish, load_out, accept;

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      finish    = ((state_ff == ST_RUN) && (step_ff == dpb_pkg::STEP_LAST)) ||
                  (state_ff == ST_HOLD);
      load_out  = finish && out_free;
      req_ready = (state_ff == ST_IDLE) || load_out;
      accept    = req_valid && req_ready;

      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               step_in  = dpb_pkg::STEP_INIT;
            end
         end
         ST_RUN: begin
            if (step_ff != dpb_pkg::STEP_LAST) begin
               step_in = step_ff + dpb_pkg::STEP_W'(1);
            end else if (load_out) begin
               state_in = accept ? ST_RUN : ST_IDLE;
               step_in  = dpb_pkg::STEP_INIT;
            end else begin
               state_in = ST_HOLD;
               step_in  = dpb_pkg::STEP_INIT;
            end
         end
         ST_HOLD: begin
            if (load_out) begin
               state_in = accept ? ST_RUN : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = dpb_pkg::STEP_INIT;
         end
      endcase

      rsp_valid_in = load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= dpb_pkg::STEP_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign cmd.accept   = accept;
   assign cmd.run      = (state_ff == ST_RUN);
   assign cmd.step     = step_ff;
   assign cmd.load_out = load_out;

endmodule
